/* rtl/ahd_pkg.sv */
// Shared types and constants of the accelerometer hit detector.
`default_nettype none

package ahd_pkg;

  localparam int unsigned AccelW   = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned LevelW   = 18;
  localparam int unsigned PowerW   = 19;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned CountW   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 18;
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 64;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t RegHitThreshold = 3'd0;
  localparam cfg_idx_t RegReleaseLevel = 3'd1;
  localparam cfg_idx_t RegCooldownMs   = 3'd2;
  localparam cfg_idx_t RegRearmCount   = 3'd3;
  localparam cfg_idx_t RegLedHoldMs    = 3'd4;

  // Register values after reset.
  localparam logic [LevelW-1:0] HitThresholdRst = 18'd650;
  localparam logic [LevelW-1:0] ReleaseLevelRst = 18'd600;
  localparam logic [HoldW-1:0]  CooldownMsRst   = 16'd55;
  localparam logic [CountW-1:0] RearmCountRst   = 8'd1;
  localparam logic [HoldW-1:0]  LedHoldMsRst    = 16'd120;

  localparam logic [CountW-1:0] QuietCountMax = {CountW{1'b1}};

  // One result item; hit sits in the lowest bit.
  typedef struct packed {
    logic                     led_white;
    logic                     armed;
    logic [LevelW-1:0]        energy_avg;
    logic [LevelW-1:0]        energy;
    logic signed [PowerW-1:0] power;
    logic                     hit;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

`default_nettype wire

/* rtl/accel_hit_detector.sv */
// Top level of the accelerometer hit detector with hysteresis and hold-off.
`default_nettype none

// Impact detector for a stream of 3-axis accelerometer samples. Each sample
// transfer produces exactly one result transfer. The energy of a sample is the
// summed absolute change of the three axes from the previous sample (zero for
// the first sample after reset); an eighth-weight running average of energy is
// kept, and hit power is energy minus that average. A hit needs the detector
// armed, hit power above hit_threshold and more than cooldown_ms milliseconds
// since the previous hit. After a hit the detector disarms and rearms after
// rearm_count consecutive samples whose power is below release_level.
// led_white stays high for led_hold_ms after a hit. All timestamp differences
// wrap modulo 2^32. The block takes one sample per clock cycle while the skid
// register is empty: the whole update runs in one combinational pass from the
// sample and the state registers into the state and result registers.
// A result register plus a one-entry skid register decouple the output side,
// so a new sample is accepted while a finished result still waits for the
// sink. Configuration is written through a plain write port with no read-back
// and must only be changed while no sample is in flight.
module accel_hit_detector (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // Configuration write port.
  input  wire                           cfg_we_i,
  input  wire ahd_pkg::cfg_idx_t        cfg_idx_i,
  input  wire [ahd_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // Sample stream.
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: accel_x[15:0], accel_y[31:16], accel_z[47:32],
  // time_ms[79:48].
  input  wire [ahd_pkg::InDataW-1:0]    s_axis_tdata,
  // Result stream.
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  // Fields from bit 0: hit[0], power[19:1], energy[37:20],
  // energy_avg[55:38], armed[56], led_white[57], zeros above.
  output logic [ahd_pkg::OutDataW-1:0]  m_axis_tdata
);
  import ahd_pkg::*;

  // Configuration registers.
  logic [LevelW-1:0] hit_threshold_q;
  logic [LevelW-1:0] release_level_q;
  logic [HoldW-1:0]  cooldown_ms_q;
  logic [CountW-1:0] rearm_count_q;
  logic [HoldW-1:0]  led_hold_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_threshold_q <= HitThresholdRst;
      release_level_q <= ReleaseLevelRst;
      cooldown_ms_q   <= CooldownMsRst;
      rearm_count_q   <= RearmCountRst;
      led_hold_ms_q   <= LedHoldMsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegHitThreshold: hit_threshold_q <= cfg_wdata_i[LevelW-1:0];
        RegReleaseLevel: release_level_q <= cfg_wdata_i[LevelW-1:0];
        RegCooldownMs:   cooldown_ms_q   <= cfg_wdata_i[HoldW-1:0];
        RegRearmCount:   rearm_count_q   <= cfg_wdata_i[CountW-1:0];
        RegLedHoldMs:    led_hold_ms_q   <= cfg_wdata_i[HoldW-1:0];
        default: ;  // Writes beyond the register list are dropped.
      endcase
    end
  end

  // Detector state.
  logic signed [AccelW-1:0] prev_x_q, prev_y_q, prev_z_q;
  logic                     seen_first_q;
  logic [LevelW-1:0]        avg_energy_q, avg_energy_d;
  logic                     armed_q, armed_d;
  logic [CountW-1:0]        quiet_count_q, quiet_count_d;
  logic [TimeW-1:0]         last_hit_q, last_hit_d;
  logic                     any_hit_q, any_hit_d;
  logic [TimeW-1:0]         white_until_q, white_until_d;

  // Sample fields.
  logic signed [AccelW-1:0] accel_x, accel_y, accel_z;
  logic [TimeW-1:0]         time_ms;

  assign accel_x = s_axis_tdata[AccelW-1:0];
  assign accel_y = s_axis_tdata[2*AccelW-1:AccelW];
  assign accel_z = s_axis_tdata[3*AccelW-1:2*AccelW];
  assign time_ms = s_axis_tdata[3*AccelW+TimeW-1:3*AccelW];

  logic s_accept;
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // Absolute difference of two 16-bit signed values fits 16 bits unsigned.
  function automatic logic [AccelW-1:0] abs_diff(logic signed [AccelW-1:0] a,
                                                 logic signed [AccelW-1:0] b);
    logic signed [AccelW:0] d;
    d = {a[AccelW-1], a} - {b[AccelW-1], b};
    abs_diff = d[AccelW] ? AccelW'(-d) : d[AccelW-1:0];
  endfunction

  logic signed [AccelW-1:0]  ref_x, ref_y, ref_z;
  logic [LevelW-1:0]         energy_d;
  logic [LevelW+2:0]         avg_sum;
  logic signed [PowerW-1:0]  power_d;
  logic signed [PowerW:0]    power_ext, thresh_ext, release_ext;
  logic                      quiet, loud, cooled, hit_d;
  logic [CountW-1:0]         quiet_inc;
  logic [TimeW-1:0]          since_hit, since_hit_d, white_span_d;
  logic                      white_d;
  result_t                   result_d;

  always_comb begin
    // On the first sample the previous sample is the sample itself.
    ref_x = seen_first_q ? prev_x_q : accel_x;
    ref_y = seen_first_q ? prev_y_q : accel_y;
    ref_z = seen_first_q ? prev_z_q : accel_z;
    energy_d = LevelW'(abs_diff(accel_x, ref_x)) + LevelW'(abs_diff(accel_y, ref_y))
             + LevelW'(abs_diff(accel_z, ref_z));

    // avg * 7 + energy, then divided by eight.
    avg_sum      = ({avg_energy_q, 3'b000} - (LevelW+3)'(avg_energy_q))
                 + (LevelW+3)'(energy_d);
    avg_energy_d = avg_sum[LevelW+2:3];
    power_d      = $signed({1'b0, energy_d}) - $signed({1'b0, avg_energy_d});

    power_ext   = {power_d[PowerW-1], power_d};
    thresh_ext  = $signed({2'b00, hit_threshold_q});
    release_ext = $signed({2'b00, release_level_q});
    quiet       = power_ext < release_ext;
    loud        = power_ext > thresh_ext;

    since_hit = time_ms - last_hit_q;
    cooled    = !any_hit_q || (since_hit > TimeW'(cooldown_ms_q));
    quiet_inc = (quiet_count_q == QuietCountMax) ? quiet_count_q : quiet_count_q + 1'b1;

    hit_d         = 1'b0;
    armed_d       = armed_q;
    quiet_count_d = quiet_count_q;
    last_hit_d    = last_hit_q;
    any_hit_d     = any_hit_q;
    white_until_d = white_until_q;

    if (!armed_q) begin
      if (quiet) begin
        quiet_count_d = quiet_inc;
        if (quiet_inc >= rearm_count_q) begin
          armed_d = 1'b1;
        end
      end else begin
        quiet_count_d = '0;
      end
    end else if (loud && cooled) begin
      hit_d         = 1'b1;
      armed_d       = 1'b0;
      quiet_count_d = '0;
      last_hit_d    = time_ms;
      any_hit_d     = 1'b1;
      white_until_d = time_ms + TimeW'(led_hold_ms_q);
    end

    // The white window is judged against the state after this sample.
    since_hit_d  = hit_d ? '0 : since_hit;
    white_span_d = hit_d ? TimeW'(led_hold_ms_q) : (white_until_q - last_hit_q);
    white_d      = any_hit_d && (since_hit_d < white_span_d);

    result_d.hit        = hit_d;
    result_d.power      = power_d;
    result_d.energy     = energy_d;
    result_d.energy_avg = avg_energy_d;
    result_d.armed      = armed_d;
    result_d.led_white  = white_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q      <= '0;
      prev_y_q      <= '0;
      prev_z_q      <= '0;
      seen_first_q  <= 1'b0;
      avg_energy_q  <= '0;
      armed_q       <= 1'b1;
      quiet_count_q <= '0;
      last_hit_q    <= '0;
      any_hit_q     <= 1'b0;
      white_until_q <= '0;
    end else if (s_accept) begin
      prev_x_q      <= accel_x;
      prev_y_q      <= accel_y;
      prev_z_q      <= accel_z;
      seen_first_q  <= 1'b1;
      avg_energy_q  <= avg_energy_d;
      armed_q       <= armed_d;
      quiet_count_q <= quiet_count_d;
      last_hit_q    <= last_hit_d;
      any_hit_q     <= any_hit_d;
      white_until_q <= white_until_d;
    end
  end

  // Result register with a one-entry skid register behind it. Input is only
  // refused once both hold a result that the sink has not taken.
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;

  assign s_axis_tready = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= s_accept;
      end
    end else if (s_accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_q <= skid_valid_q ? skid_q : result_d;
    end else if (s_accept) begin
      skid_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-ResultW){1'b0}}, out_q};

  // A filled skid register always sits behind a filled result register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while the result register is empty");

  // A hit disarms the detector and records its timestamp.
  a_hit_updates_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && hit_d) |=> (!armed_q && any_hit_q && last_hit_q == $past(time_ms)))
    else $error("hit did not update the detector state");

  // A delivered hit result never reports the detector as armed.
  a_hit_disarmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.hit) |-> !out_q.armed)
    else $error("hit result reports an armed detector");

  // The first sample after reset carries no energy.
  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && !seen_first_q) |-> (energy_d == '0))
    else $error("first sample produced nonzero energy");

endmodule

`default_nettype wire

/* test/tb_accel_hit_detector.sv */
// Self-checking testbench for the accelerometer hit detector top level.
`timescale 1ns / 100ps

// The testbench drives accelerometer samples into the detector and checks every result
// against its own model of the detector state. An initial block writes the configuration
// while the block is idle and fills a queue of pending samples. A clocked driver moves
// those samples onto the input stream, and a clocked monitor takes results from the output
// stream. Both sides idle in random bursts, except in the final phase.
module tb_accel_hit_detector;
  import ahd_pkg::*;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  cfg_idx_t             cfg_idx_i     = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  wire                  s_axis_tready;
  // Fields from bit 0: accel_x, accel_y, accel_z, time_ms.
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  wire                  m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // Fields from bit 0: hit, power, energy, energy_avg, armed, led_white.
  wire  [OutDataW-1:0]  m_axis_tdata;

  accel_hit_detector uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the configuration registers, starting from their reset values.
  logic [LevelW-1:0] thr_q   = HitThresholdRst;
  logic [LevelW-1:0] rel_q   = ReleaseLevelRst;
  logic [HoldW-1:0]  cool_q  = CooldownMsRst;
  logic [CountW-1:0] rsamp_q = RearmCountRst;
  logic [HoldW-1:0]  hold_q  = LedHoldMsRst;

  // Tracked detector state, starting from the state after reset.
  logic signed [AccelW-1:0] prev_x = '0, prev_y = '0, prev_z = '0;
  logic                     seen_first  = 1'b0;
  logic [LevelW-1:0]        avg_energy  = '0;
  logic                     armed_st    = 1'b1;
  logic [CountW-1:0]        quiet_cnt   = '0;
  logic [TimeW-1:0]         last_hit_ms = '0;
  logic                     any_hit     = 1'b0;
  logic [TimeW-1:0]         white_until = '0;

  logic [InDataW-1:0] sample_q[$];   // Samples waiting for the driver.
  result_t            outcome_q[$];  // Results the detector owes, oldest first.

  bit failed   = 1'b0;
  bit idle_ok  = 1'b1;  // Cleared for the final phase, where neither side idles.
  int send_gap = 0;
  int recv_gap = 0;
  int pushed   = 0;

  // Generator position: the current axis values and timestamp of the sample stream.
  int               gen_x = 0, gen_y = 0, gen_z = 0;
  logic [TimeW-1:0] gen_t = '0;

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Advances the tracked state by one accepted sample and returns the result it yields.
  function automatic result_t track_sample(input logic [InDataW-1:0] d);
    logic signed [AccelW-1:0] x, y, z;
    logic [TimeW-1:0]         now, since, span;
    int                       en, pw;
    result_t                  r;
    x   = d[15:0];
    y   = d[31:16];
    z   = d[47:32];
    now = d[79:48];
    // The first sample after reset is its own predecessor, so its energy is zero.
    if (!seen_first) begin
      prev_x     = x;
      prev_y     = y;
      prev_z     = z;
      seen_first = 1'b1;
    end
    en = mag(int'(x) - int'(prev_x)) + mag(int'(y) - int'(prev_y)) +
         mag(int'(z) - int'(prev_z));
    prev_x = x;
    prev_y = y;
    prev_z = z;
    avg_energy = LevelW'((int'(avg_energy) * 7 + en) / 8);
    pw = en - int'(avg_energy);
    since = now - last_hit_ms;
    r = '0;
    if (!armed_st) begin
      // While disarmed, quiet samples count up toward rearming and a loud one starts over.
      if (pw < int'(rel_q)) begin
        if (quiet_cnt != QuietCountMax) quiet_cnt = quiet_cnt + 1'b1;
        if (quiet_cnt >= rsamp_q) armed_st = 1'b1;
      end else begin
        quiet_cnt = '0;
      end
    end else if (pw > int'(thr_q) && (!any_hit || since > TimeW'(cool_q))) begin
      // Before the first hit there is no cooldown to wait out.
      r.hit       = 1'b1;
      last_hit_ms = now;
      any_hit     = 1'b1;
      armed_st    = 1'b0;
      quiet_cnt   = '0;
      white_until = now + TimeW'(hold_q);
    end
    // The white hold is judged on wrapped distances from the last hit.
    since = now - last_hit_ms;
    span  = white_until - last_hit_ms;
    r.power      = PowerW'(pw);
    r.energy     = LevelW'(en);
    r.energy_avg = avg_energy;
    r.armed      = armed_st;
    r.led_white  = any_hit && (since < span);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Driver: moves pending samples onto the input stream, with random gaps between
  // transfers. Valid is held until the transfer completes.
  always @(posedge clk_i) begin : drive_samples
    logic               nv;
    logic [InDataW-1:0] nd;
    nv = s_axis_tvalid;
    nd = s_axis_tdata;
    if (!rst_ni) begin
      nv = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        outcome_q.push_back(track_sample(s_axis_tdata));
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (idle_ok && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 9);
        end else if (sample_q.size() != 0) begin
          nd = sample_q.pop_front();
          nv = 1'b1;
        end
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata  <= nd;
  end

  // Monitor: checks each result transfer against the oldest owed result and
  // stalls the output side in random bursts.
  always @(posedge clk_i) begin : check_results
    result_t got, want;
    logic    nr;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[ResultW-1:0]);
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, m_axis_tdata);
        failed = 1'b1;
      end else begin
        want = outcome_q.pop_front();
        check_field("hit", 64'(want.hit), 64'(got.hit));
        check_field("power", 64'(unsigned'(want.power)), 64'(unsigned'(got.power)));
        check_field("energy", 64'(want.energy), 64'(got.energy));
        check_field("energy_avg", 64'(want.energy_avg), 64'(got.energy_avg));
        check_field("armed", 64'(want.armed), 64'(got.armed));
        check_field("led_white", 64'(want.led_white), 64'(got.led_white));
        check_field("padding", '0, 64'(m_axis_tdata[OutDataW-1:ResultW]));
      end
    end
    if (!rst_ni) begin
      nr = 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      nr = 1'b0;
    end else if (idle_ok && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(0, 9);
      nr = 1'b0;
    end else begin
      nr = 1'b1;
    end
    m_axis_tready <= nr;
  end

  task automatic push_sample();
    sample_q.push_back({gen_t, 16'(gen_z), 16'(gen_y), 16'(gen_x)});
    pushed++;
  endtask

  task automatic place(input int x, input int y, input int z, input logic [TimeW-1:0] t);
    gen_x = x;
    gen_y = y;
    gen_z = z;
    gen_t = t;
    push_sample();
  endtask

  // Small jitter around the current position with short time steps.
  task automatic add_quiet(input int n);
    repeat (n) begin
      gen_x = clamp16(gen_x + int'($urandom_range(0, 40)) - 20);
      gen_y = clamp16(gen_y + int'($urandom_range(0, 40)) - 20);
      gen_z = clamp16(gen_z + int'($urandom_range(0, 40)) - 20);
      gen_t = gen_t + $urandom_range(0, 15);
      push_sample();
    end
  endtask

  // One large jump on every axis, the kind of sample that should trigger a hit.
  task automatic add_spike();
    int d;
    d = int'($urandom_range(100, 20000));
    gen_x = clamp16(gen_x + ($urandom_range(0, 1) ? d : -d));
    d = int'($urandom_range(100, 20000));
    gen_y = clamp16(gen_y + ($urandom_range(0, 1) ? d : -d));
    d = int'($urandom_range(100, 20000));
    gen_z = clamp16(gen_z + ($urandom_range(0, 1) ? d : -d));
    gen_t = gen_t + $urandom_range(1, 30);
    push_sample();
  endtask

  // Arbitrary values over the full range of every axis; the timestamp is random or steps forward.
  task automatic add_noise();
    gen_x = int'($urandom_range(0, 65535)) - 32768;
    gen_y = int'($urandom_range(0, 65535)) - 32768;
    gen_z = int'($urandom_range(0, 65535)) - 32768;
    if ($urandom_range(0, 1)) gen_t = $urandom;
    else gen_t = gen_t + $urandom_range(0, 200);
    push_sample();
  endtask

  // Mostly quiet stretches ending in a spike, mixed with noise, time jumps and
  // long quiet runs that can satisfy even the largest rearm count.
  task automatic run_random(input int n);
    int stop, kind;
    stop = pushed + n;
    while (pushed < stop) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        add_quiet($urandom_range(1, 12));
        add_spike();
      end else if (kind < 70) begin
        add_spike();
      end else if (kind < 85) begin
        add_noise();
      end else if (kind < 92) begin
        gen_t = gen_t + $urandom;
        add_quiet($urandom_range(1, 4));
      end else if (kind < 98) begin
        add_quiet($urandom_range(1, 12));
      end else begin
        add_quiet($urandom_range(200, 270));
      end
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      RegHitThreshold: thr_q   = val;
      RegReleaseLevel: rel_q   = val;
      RegCooldownMs:   cool_q  = val[HoldW-1:0];
      RegRearmCount:   rsamp_q = val[CountW-1:0];
      RegLedHoldMs:    hold_q  = val[HoldW-1:0];
      default: ;
    endcase
  endtask

  // Writes all registers back to back. Narrow registers get random bits above their
  // width, which the block must drop, and an index past the register list is written
  // with random data, which the block must ignore.
  task automatic set_config(input logic [LevelW-1:0] thr, input logic [LevelW-1:0] rel,
                            input logic [HoldW-1:0] cool, input logic [CountW-1:0] rsamp,
                            input logic [HoldW-1:0] hold);
    write_reg(RegHitThreshold, thr);
    write_reg(RegReleaseLevel, rel);
    write_reg(RegCooldownMs, {2'($urandom_range(0, 3)), cool});
    write_reg(RegRearmCount, {10'($urandom_range(0, 1023)), rsamp});
    write_reg(cfg_idx_t'(RegLedHoldMs + 1 + $urandom_range(0, 2)), CfgDataW'($urandom));
    write_reg(RegLedHoldMs, {2'($urandom_range(0, 3)), hold});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every sample has been sent and every result checked, plus a margin.
  task automatic drain();
    while (sample_q.size() != 0 || outcome_q.size() != 0 || s_axis_tvalid || m_axis_tvalid)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed samples under the reset configuration. The first sample has zero energy.
    // A full-scale swing follows with no earlier hit. Then a spike inside the cooldown,
    // one just past it, the white hold at its last millisecond and just after it, and
    // hits across the wrap of the timestamp.
    place(1000, -2000, 3000, 32'd0);
    place(1000, -2000, 3000, 32'd1);
    place(-32768, -32768, -32768, 32'd10);
    place(32767, 32767, 32767, 32'd20);
    place(32767, 32767, 32767, 32'd30);
    place(0, 0, 0, 32'd40);
    place(0, 0, 0, 32'd50);
    place(-30000, 30000, -30000, 32'd70);
    place(-30000, 30000, -30000, 32'd80);
    place(-30000, 30000, -30000, 32'd189);
    place(-30000, 30000, -30000, 32'd190);
    place(-30000, 30000, -30000, 32'hFFFF_FFF0);
    place(20000, -20000, 20000, 32'hFFFF_FFF8);
    place(20000, -20000, 20000, 32'h0000_0005);
    place(20000, -20000, 20000, 32'h0000_0006);
    place(-20000, 20000, -20000, 32'h0000_0030);
    place(-20000, 20000, -20000, 32'h0000_0031);
    place(-20000, 20000, -20000, 32'h0000_0031);
    place(-32768, 32767, -32768, 32'h0000_0040);
    place(32767, -32768, 32767, 32'h0000_0041);
    drain();

    // Reset values written explicitly, then random traffic.
    set_config(HitThresholdRst, ReleaseLevelRst, CooldownMsRst, RearmCountRst,
               LedHoldMsRst);
    run_random(200);
    drain();

    // All registers at their minimum: a zero rearm count rearms on the first quiet sample,
    // and a zero hold never shows white.
    set_config('0, '0, '0, '0, '0);
    run_random(200);
    drain();

    // All registers at their maximum: no hit can pass the threshold.
    set_config({LevelW{1'b1}}, {LevelW{1'b1}}, {HoldW{1'b1}}, {CountW{1'b1}}, {HoldW{1'b1}});
    run_random(150);
    drain();

    // Low threshold with the longest cooldown and rearm count.
    set_config(18'd100, {LevelW{1'b1}}, {HoldW{1'b1}}, {CountW{1'b1}}, 16'd500);
    run_random(200);
    drain();

    set_config(18'd2000, 18'd1500, 16'd10, 8'd3, 16'd30);
    run_random(200);
    drain();

    set_config(LevelW'($urandom_range(0, 5000)), LevelW'($urandom_range(0, 5000)),
               HoldW'($urandom_range(0, 100)), CountW'($urandom_range(0, 8)),
               HoldW'($urandom_range(0, 300)));
    run_random(200);
    drain();

    set_config(LevelW'($urandom), LevelW'($urandom), HoldW'($urandom), CountW'($urandom),
               HoldW'($urandom));
    run_random(150);
    drain();

    // Final phase: back-to-back transfers on both sides.
    idle_ok = 1'b0;
    set_config(LevelW'($urandom_range(300, 1500)), LevelW'($urandom_range(200, 1500)),
               HoldW'($urandom_range(0, 60)), CountW'($urandom_range(1, 4)),
               HoldW'($urandom_range(0, 200)));
    run_random(200);
    drain();

    repeat (10) @(posedge clk_i);
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // The slowest correct run takes well under a tenth of this.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
